@@ rtl/core/lrcf_pkg.sv @@
// ----------------------------------------------------------------------------
// lrcf_pkg
// Types and constants shared by the log record chunk framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrcf_pkg;

   localparam int unsigned CHUNK_MAX   = 65535;
   localparam int unsigned FRAME_BYTES = 7;
   localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

   localparam logic [7:0] MARK_SYNC  = 8'h08;
   localparam logic [7:0] MARK_ASYNC = 8'h09;
   localparam logic [7:0] MARK_END   = 8'h00;

   localparam logic MODE_SYNC  = 1'b0;
   localparam logic MODE_ASYNC = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  data_byte;
      logic [30:0] record_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       record_done;
   } rsp_type;

   // bytes go out from index 0 upward; count 0 means no output
   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]            count;
      logic                        done;
   } frame_type;

endpackage

`default_nettype wire

@@ rtl/core/lrcf_framer.sv @@
// ----------------------------------------------------------------------------
// lrcf_framer
// Record and chunk state; builds the framed bytes for one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lrcf_framer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lrcf_pkg::req_type   req,
   input  wire logic                accept,
   output lrcf_pkg::frame_type      frame
);

   logic [15:0] seq_ff, seq_in;
   logic [30:0] rec_left_ff, rec_left_in;
   logic [15:0] chk_left_ff, chk_left_in;
   logic        mode_ff, mode_in;

   logic        start, drop, new_chunk, trailer;
   logic [30:0] rec_eff;
   logic [15:0] chk_eff, clen, seq_inc, seq_out;
   logic        mode_eff;

   always_comb begin
      start     = (rec_left_ff == '0);
      drop      = start && (req.record_length == '0);
      rec_eff   = start ? req.record_length : rec_left_ff;
      mode_eff  = start ? req.mode : mode_ff;
      chk_eff   = start ? 16'd0 : chk_left_ff;
      new_chunk = (chk_eff == '0);

      if (rec_eff > 31'(lrcf_pkg::CHUNK_MAX)) begin
         clen = 16'(lrcf_pkg::CHUNK_MAX);
      end else begin
         clen = rec_eff[15:0];
      end
      if (clen == '0) begin
         clen = 16'd1;
      end

      seq_inc = seq_ff + 16'd1;
      if (seq_inc == '0) begin
         seq_inc = 16'd1;
      end
      seq_out = (mode_eff == lrcf_pkg::MODE_SYNC) ? seq_inc : 16'd0;

      chk_left_in = (new_chunk ? clen : chk_eff) - 16'd1;
      rec_left_in = rec_eff - 31'd1;
      mode_in     = mode_eff;
      seq_in      = (new_chunk && mode_eff == lrcf_pkg::MODE_SYNC) ? seq_inc : seq_ff;
      trailer     = (chk_left_in == '0);

      frame.bytes = '0;
      if (new_chunk) begin
         frame.bytes[0] = (mode_eff == lrcf_pkg::MODE_SYNC) ? lrcf_pkg::MARK_SYNC
                                                           : lrcf_pkg::MARK_ASYNC;
         frame.bytes[1] = seq_out[7:0];
         frame.bytes[2] = seq_out[15:8];
         frame.bytes[3] = clen[7:0];
         frame.bytes[4] = clen[15:8];
         frame.bytes[5] = req.data_byte;
         frame.bytes[6] = lrcf_pkg::MARK_END;
      end else begin
         frame.bytes[0] = req.data_byte;
         frame.bytes[1] = lrcf_pkg::MARK_END;
      end

      if (drop) begin
         frame.count = '0;
      end else begin
         frame.count = lrcf_pkg::CNT_W'(1)
                     + (new_chunk ? lrcf_pkg::CNT_W'(5) : lrcf_pkg::CNT_W'(0))
                     + (trailer ? lrcf_pkg::CNT_W'(1) : lrcf_pkg::CNT_W'(0));
      end
      frame.done = trailer && (rec_left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= '0;
         rec_left_ff <= '0;
         chk_left_ff <= '0;
         mode_ff     <= '0;
      end else if (accept && !drop) begin
         seq_ff      <= seq_in;
         rec_left_ff <= rec_left_in;
         chk_left_ff <= chk_left_in;
         mode_ff     <= mode_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lrcf_serializer.sv @@
// ----------------------------------------------------------------------------
// lrcf_serializer
// Holds one beat's framed bytes and shifts them out through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrcf_serializer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lrcf_pkg::frame_type frame,
   input  wire logic                accept,
   output logic                     ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output lrcf_pkg::rsp_type        rsp_data
);

   logic [lrcf_pkg::FRAME_BYTES-1:0][7:0] buf_ff, buf_in;
   logic [lrcf_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic                                  done_ff, done_in;
   logic                                  out_valid_ff, out_valid_in;
   lrcf_pkg::rsp_type                     out_ff, out_in;
   logic                                  take;

   always_comb begin
      take  = (cnt_ff != '0) && (!out_valid_ff || rsp_ready);
      ready = (cnt_ff == '0) || ((cnt_ff == lrcf_pkg::CNT_W'(1)) && take);

      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (accept) begin
         buf_in  = frame.bytes;
         cnt_in  = frame.count;
         done_in = frame.done;
      end else if (take) begin
         buf_in  = {8'h00, buf_ff[lrcf_pkg::FRAME_BYTES-1:1]};
         cnt_in  = cnt_ff - lrcf_pkg::CNT_W'(1);
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (take) begin
         out_in.out_byte    = buf_ff[0];
         out_in.last_of_run = (cnt_ff == lrcf_pkg::CNT_W'(1));
         out_in.record_done = (cnt_ff == lrcf_pkg::CNT_W'(1)) && done_ff;
         out_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      done_ff <= done_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

@@ rtl/core/log_record_chunk_framer.sv @@
// ----------------------------------------------------------------------------
// log_record_chunk_framer
// Frames a byte-serial log record into chunks with marker, sequence number,
// length header and trailer.
//
//   channel  dir  beat contents
//   req_     in   mode, data_byte, record_length (length/mode used on first byte)
//   rsp_     out  out_byte, last_of_run, record_done
//
// An input beat yields 0 to 7 output beats, one per cycle while rsp_ready holds;
// a plain data byte yields one, so inside a chunk one input beat per cycle.
// The next input beat is taken in the cycle the previous beat's last byte moves
// into the output register. Output stalls back up through the byte buffer.
// Reset is synchronous and clears all record and sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_chunk_framer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lrcf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lrcf_pkg::rsp_type      rsp_data
);

   lrcf_pkg::frame_type frame;
   logic                accept;

   assign accept = req_valid && req_ready;

   lrcf_framer u_framer (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .accept (accept),
      .frame  (frame)
   );

   lrcf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .accept    (accept),
      .ready     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/log_record_chunk_framer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_record_chunk_framer_tb
// Feeds log records byte by byte into the framer and checks every framed
// output beat against an in-bench prediction of markers, sequence numbers,
// chunk lengths, data and trailers. The run covers zero-length bytes, mode
// changes inside a record, a maximum-length record, a stretch with no idling
// and a long output stall, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_chunk_framer_tb;

   class frame_scoreboard;
      lrcf_pkg::rsp_type expected_bytes[$];
      logic [15:0]       seq_count;
      logic [30:0]       record_left;
      logic [15:0]       chunk_left;
      logic              record_mode;
      int                errors;
      int                received;

      function new();
         seq_count   = '0;
         record_left = '0;
         chunk_left  = '0;
         record_mode = lrcf_pkg::MODE_SYNC;
         errors      = 0;
         received    = 0;
      endfunction

      task flag_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void push_byte(logic [7:0] b);
         lrcf_pkg::rsp_type r;
         r.out_byte    = b;
         r.last_of_run = 1'b0;
         r.record_done = 1'b0;
         expected_bytes.push_back(r);
      endfunction

      function void note_input(lrcf_pkg::req_type r);
         logic [15:0] clen;
         logic [15:0] seq_field;
         if (record_left == '0) begin
            if (r.record_length == '0)
               return;
            record_left = r.record_length;
            record_mode = r.mode;
            chunk_left  = '0;
         end
         if (chunk_left == '0) begin
            clen = (record_left > lrcf_pkg::CHUNK_MAX) ? 16'(lrcf_pkg::CHUNK_MAX)
                                                       : record_left[15:0];
            seq_field = '0;
            if (record_mode == lrcf_pkg::MODE_SYNC) begin
               seq_count = seq_count + 16'd1;
               if (seq_count == '0)
                  seq_count = 16'd1;
               seq_field = seq_count;
            end
            push_byte((record_mode == lrcf_pkg::MODE_SYNC) ? lrcf_pkg::MARK_SYNC
                                                           : lrcf_pkg::MARK_ASYNC);
            push_byte(seq_field[7:0]);
            push_byte(seq_field[15:8]);
            push_byte(clen[7:0]);
            push_byte(clen[15:8]);
            chunk_left = clen;
         end
         push_byte(r.data_byte);
         chunk_left  = chunk_left - 16'd1;
         record_left = record_left - 31'd1;
         if (chunk_left == '0) begin
            push_byte(lrcf_pkg::MARK_END);
            if (record_left == '0)
               expected_bytes[expected_bytes.size()-1].record_done = 1'b1;
         end
         expected_bytes[expected_bytes.size()-1].last_of_run = 1'b1;
      endfunction

      task check_result(lrcf_pkg::rsp_type got);
         lrcf_pkg::rsp_type want;
         received++;
         if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("beat %0d: unexpected output byte %02h",
                                    received, got.out_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            flag_mismatch($sformatf("beat %0d: out_byte %02h, want %02h",
                                    received, got.out_byte, want.out_byte));
         if (got.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("beat %0d: last_of_run %b, want %b",
                                    received, got.last_of_run, want.last_of_run));
         if (got.record_done !== want.record_done)
            flag_mismatch($sformatf("beat %0d: record_done %b, want %b",
                                    received, got.record_done, want.record_done));
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lrcf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lrcf_pkg::rsp_type rsp_data;

   bit quiet = 1'b0;
   bit held  = 1'b0;

   frame_scoreboard board = new();

   log_record_chunk_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_beat(input lrcf_pkg::req_type r);
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_input(r);
   endtask

   task automatic send_one(input logic m, input logic [7:0] d, input logic [30:0] len);
      lrcf_pkg::req_type r;
      r.mode          = m;
      r.data_byte     = d;
      r.record_length = len;
      send_beat(r);
   endtask

   // first beat carries length and mode; later beats carry junk in both
   task automatic send_record(input logic [30:0] len, input logic m, input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         send_one((i == 0) ? m : 1'($urandom), 8'($urandom),
                  (i == 0) ? len : 31'($urandom));
      end
   endtask

   // receiver with random stalls and one long hold-off
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!held && board.received >= 100) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 23);
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_data);
      end
   end

   initial begin
      int       items;
      int       len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero length, data extremes, both modes, mode change mid-record
      send_one(lrcf_pkg::MODE_SYNC, 8'h5A, 31'd0);
      send_one(lrcf_pkg::MODE_SYNC, 8'h00, 31'd1);
      send_one(lrcf_pkg::MODE_ASYNC, 8'hFF, 31'd1);
      send_one(lrcf_pkg::MODE_ASYNC, 8'hA5, 31'd0);
      send_one(lrcf_pkg::MODE_SYNC, 8'h80, 31'd3);
      send_one(lrcf_pkg::MODE_ASYNC, 8'h01, 31'h7FFF_FFFF);
      send_one(lrcf_pkg::MODE_ASYNC, 8'h7F, 31'd0);
      send_one(lrcf_pkg::MODE_ASYNC, 8'hAA, 31'd4);
      send_one(lrcf_pkg::MODE_SYNC, 8'h55, 31'h5555_5555);
      send_one(lrcf_pkg::MODE_SYNC, 8'hFF, 31'h2AAA_AAAA);
      send_one(lrcf_pkg::MODE_SYNC, 8'h00, 31'd1);
      send_one(lrcf_pkg::MODE_SYNC, 8'hC3, 31'd2);
      send_one(lrcf_pkg::MODE_ASYNC, 8'h3C, 31'd0);
      send_one(lrcf_pkg::MODE_ASYNC, 8'hFE, 31'd0);

      // random records, mostly short, with zero-length noise between them
      items = 0;
      while (items < 400) begin
         if ($urandom_range(9) == 0) begin
            send_one(1'($urandom), 8'($urandom), 31'd0);
         end else begin
            if ($urandom_range(39) == 0)
               len = $urandom_range(300, 200);
            else if ($urandom_range(4) == 0)
               len = $urandom_range(40, 9);
            else
               len = $urandom_range(8, 1);
            send_record(31'(len), 1'($urandom), len);
            items += len;
         end
      end

      // no idling on either side: a long record, then one-byte records
      quiet = 1'b1;
      send_record(31'd60, lrcf_pkg::MODE_SYNC, 60);
      for (int i = 0; i < 20; i++)
         send_record(31'd1, 1'($urandom), 1);
      quiet = 1'b0;

      // maximum length record, left open
      send_record(31'h7FFF_FFFF, lrcf_pkg::MODE_ASYNC, 5);
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.pending() != 0)
         board.flag_mismatch($sformatf("%0d expected beats never arrived", board.pending()));
      if (board.errors == 0)
         $display("log_record_chunk_framer_tb: clean");
      else
         $display("log_record_chunk_framer_tb: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("log_record_chunk_framer_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
